### rtl/gsd_pkg.sv
// Shared constants, codes and types of the glitch and stutter delay line.
package gsd_pkg;

    // The store depth must be a power of two; addresses wrap by truncation.
    localparam int STORE_DEPTH         = 16384;
    localparam int ADDR_W              = $clog2(STORE_DEPTH);
    localparam int WPS_W               = ADDR_W + 1;
    localparam int SECOND_REGION_START = 8192;
    localparam int SAMPLE_RATE_HZ      = 44118;
    localparam int MS_PER_SECOND       = 1000;
    localparam int LED_OFF_INDEX       = 800;

    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int MS_W      = 16;
    localparam int COUNT_W   = 8;
    localparam int LOOP_W    = 15;
    localparam int NUM_TAPS  = 4;
    localparam int TAP_SEL_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Milliseconds to samples: whole part times ms plus the fractional part
    // divided by a thousand through a reciprocal and one correction step.
    localparam int RATE_INT    = SAMPLE_RATE_HZ / MS_PER_SECOND;
    localparam int RATE_FRAC   = SAMPLE_RATE_HZ % MS_PER_SECOND;
    localparam int Y_W         = MS_W + $clog2(MS_PER_SECOND);
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(MS_PER_SECOND) + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / MS_PER_SECOND);

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_SET_DELAY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_STUTTER_MODE,
        CFG_CYCLE_LIMIT,
        CFG_LOOP_LENGTH,
        CFG_LAG_COUNT,
        CFG_RECORD_HOLD
    } cfg_idx_t;

    typedef struct packed {
        logic               enable;
        logic               stutter_mode;
        logic [COUNT_W-1:0] cycle_limit;
        logic [LOOP_W-1:0]  loop_length;
        logic [COUNT_W-1:0] lag_count;
        logic               record_hold;
    } cfg_t;

    // One sample's memory work: up to two writes and four tap reads.
    typedef struct packed {
        logic [1:0]                       wr_en;
        logic [ADDR_W-1:0]                wr_addr0;
        logic [ADDR_W-1:0]                wr_addr1;
        logic [SAMPLE_W-1:0]              sample;
        logic [NUM_TAPS-1:0][ADDR_W-1:0]  rd_addr;
        logic                             stutter;
        logic                             led;
    } job_t;

endpackage

### rtl/gsd_ctrl.sv
// Position, phase and loop bookkeeping, and the set-delay conversion.
module gsd_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gsd_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic signed [gsd_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                              block_last,
    input  logic [gsd_pkg::TAP_SEL_W-1:0]     tap_select,
    input  logic [gsd_pkg::MS_W-1:0]          delay_ms,
    input  logic                              job_ready,
    output logic                              job_valid,
    output gsd_pkg::job_t                     job
);
    import gsd_pkg::*;

    typedef enum logic [1:0] {
        DLY_IDLE,
        DLY_MUL,
        DLY_RECIP,
        DLY_FIX
    } dly_state_t;

    dly_state_t                      dly_state_reg, dly_state_next;
    logic [ADDR_W-1:0]               write_pos_reg, write_pos_next;
    logic [WPS_W-1:0]                wps_reg, wps_next;
    logic [NUM_TAPS-1:0][TAP_W-1:0]  tap_reg, tap_next;
    logic                            phase_reg, phase_next;
    logic [COUNT_W-1:0]              pass_reg, pass_next;
    logic                            led_reg, led_next;

    logic [MS_W-1:0]                 ms_reg;
    logic [TAP_SEL_W-1:0]            sel_reg;
    logic [Y_W-1:0]                  y_reg;
    logic [MS_W-1:0]                 q0_reg;

    logic                            in_accept;
    logic [Y_W+RECIP_W-1:0]          recip_prod;
    logic [Y_W-1:0]                  rem;
    logic [MS_W-1:0]                 q_fix;
    logic [MS_W-1:0]                 d_samples;
    logic [ADDR_W-1:0]               dly_pos;
    logic [NUM_TAPS-1:0][ADDR_W-1:0] tap_wrap_inc;
    logic [TAP_W-1:0]                t0_adv, t1_adv;
    logic [COUNT_W-1:0]              pass_inc;
    logic                            rec;

    assign in_ready  = (dly_state_reg == DLY_IDLE) && job_ready;
    assign in_accept = in_valid && in_ready;

    // Set-delay datapath, one registered step per state.
    assign recip_prod = {{RECIP_W{1'b0}}, y_reg} * {{Y_W{1'b0}}, RECIP};
    assign rem        = y_reg - Y_W'(q0_reg) * Y_W'(MS_PER_SECOND);
    assign q_fix      = q0_reg + MS_W'(rem >= Y_W'(MS_PER_SECOND));
    assign d_samples  = MS_W'(32'(ms_reg) * 32'(RATE_INT)) + q_fix;
    assign dly_pos    = write_pos_reg - d_samples[ADDR_W-1:0];

    always_comb
    begin
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            tap_wrap_inc[k] = tap_reg[k][ADDR_W-1:0] + ADDR_W'(1);
        end
    end

    assign t0_adv = phase_reg ? tap_reg[0] : tap_reg[0] + TAP_W'(1);
    assign t1_adv = phase_reg ? tap_reg[1] : tap_reg[1] + TAP_W'(1);
    assign pass_inc = pass_reg + COUNT_W'(1);
    assign rec = phase_reg && !cfg.record_hold;

    always_comb
    begin
        dly_state_next = dly_state_reg;
        write_pos_next = write_pos_reg;
        wps_next       = wps_reg;
        tap_next       = tap_reg;
        phase_next     = phase_reg;
        pass_next      = pass_reg;
        led_next       = led_reg;
        job_valid      = 1'b0;
        job            = '0;
        job.sample     = sample_in;
        job.stutter    = cfg.stutter_mode;

        case (dly_state_reg)
            DLY_IDLE:
            begin
                if (in_accept && operation == OP_SET_DELAY)
                begin
                    dly_state_next = DLY_MUL;
                end
            end
            DLY_MUL:   dly_state_next = DLY_RECIP;
            DLY_RECIP: dly_state_next = DLY_FIX;
            DLY_FIX:
            begin
                dly_state_next = DLY_IDLE;
                if (!cfg.stutter_mode)
                begin
                    tap_next[sel_reg] = TAP_W'(dly_pos);
                end
            end
            default:   dly_state_next = DLY_IDLE;
        endcase

        if (in_accept && operation == OP_SAMPLE)
        begin
            phase_next = block_last ? 1'b1 : ~phase_reg;
            if (cfg.enable)
            begin
                job_valid = 1'b1;
                for (int k = 0; k < NUM_TAPS; k++)
                begin
                    job.rd_addr[k] = tap_reg[k][ADDR_W-1:0];
                end
                if (!cfg.stutter_mode)
                begin
                    job.wr_en[0] = phase_reg;
                    job.wr_addr0 = write_pos_reg;
                    if (phase_reg)
                    begin
                        write_pos_next = write_pos_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_TAPS; k++)
                        begin
                            tap_next[k] = TAP_W'(tap_wrap_inc[k]);
                        end
                    end
                end
                else
                begin
                    if (rec && WPS_W'(write_pos_reg) < WPS_W'(SECOND_REGION_START))
                    begin
                        job.wr_en[0]   = 1'b1;
                        job.wr_addr0   = write_pos_reg;
                        write_pos_next = write_pos_reg + ADDR_W'(1);
                    end
                    if (rec && wps_reg < WPS_W'(STORE_DEPTH))
                    begin
                        job.wr_en[1] = 1'b1;
                        job.wr_addr1 = wps_reg[ADDR_W-1:0];
                        wps_next     = wps_reg + WPS_W'(1);
                    end
                    tap_next[0] = t0_adv;
                    tap_next[1] = t1_adv;
                    if (block_last)
                    begin
                        // A completed loop pass restarts the taps and may
                        // restart either recorder.
                        if (t0_adv >= TAP_W'(cfg.loop_length))
                        begin
                            led_next = 1'b1;
                            if (pass_inc == cfg.lag_count)
                            begin
                                wps_next = WPS_W'(SECOND_REGION_START);
                            end
                            if (pass_inc >= cfg.cycle_limit)
                            begin
                                pass_next      = '0;
                                write_pos_next = '0;
                            end
                            else
                            begin
                                pass_next = pass_inc;
                            end
                            tap_next[0] = '0;
                            tap_next[1] = TAP_W'(SECOND_REGION_START);
                        end
                        else if (t0_adv >= TAP_W'(LED_OFF_INDEX))
                        begin
                            led_next = 1'b0;
                        end
                    end
                end
                job.led = led_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_state_reg <= DLY_IDLE;
            write_pos_reg <= '0;
            wps_reg       <= '0;
            tap_reg       <= '0;
            phase_reg     <= 1'b1;
            pass_reg      <= '0;
            led_reg       <= 1'b0;
        end
        else
        begin
            dly_state_reg <= dly_state_next;
            write_pos_reg <= write_pos_next;
            wps_reg       <= wps_next;
            tap_reg       <= tap_next;
            phase_reg     <= phase_next;
            pass_reg      <= pass_next;
            led_reg       <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && operation == OP_SET_DELAY)
        begin
            ms_reg  <= delay_ms;
            sel_reg <= tap_select;
        end
        if (dly_state_reg == DLY_MUL)
        begin
            y_reg <= Y_W'(ms_reg) * Y_W'(RATE_FRAC);
        end
        if (dly_state_reg == DLY_RECIP)
        begin
            q0_reg <= recip_prod[RECIP_SHIFT +: MS_W];
        end
    end

endmodule

### rtl/gsd_mem_seq.sv
// Sample memory with its access sequencer, write forwarding and result register.
module gsd_mem_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  gsd_pkg::job_t                       job,
    output logic                                job_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gsd_pkg::SAMPLE_W-1:0] tap_one,
    output logic signed [gsd_pkg::SAMPLE_W-1:0] tap_two,
    output logic signed [gsd_pkg::SAMPLE_W-1:0] tap_three,
    output logic signed [gsd_pkg::SAMPLE_W-1:0] tap_four,
    output logic                                led_on
);
    import gsd_pkg::*;

    localparam int CNT_W = $clog2(NUM_TAPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TAPS - 1);

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic                clr_busy_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    job_t                job_reg;

    logic                rd_pend_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                rd_fwd_reg;
    logic [SAMPLE_W-1:0] rd_sample_reg;
    logic                rd_led_reg;
    logic                rd_stut_reg;
    logic [SAMPLE_W-1:0] mem_q_reg;
    logic [NUM_TAPS-2:0][SAMPLE_W-1:0] asm_reg;

    logic                out_valid_reg;
    logic [NUM_TAPS-1:0][SAMPLE_W-1:0] out_tap_reg;
    logic                out_led_reg;

    logic                issue;
    logic                finish;
    logic [ADDR_W-1:0]   rd_addr;
    logic                fwd;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic [SAMPLE_W-1:0] rd_val;

    // The last read of a job waits until the result register is empty.
    assign issue     = busy_reg && (cnt_reg != CNT_LAST || !out_valid_reg);
    assign finish    = issue && cnt_reg == CNT_LAST;
    assign job_ready = !clr_busy_reg && (!busy_reg || finish);
    assign rd_addr   = job_reg.rd_addr[cnt_reg];

    // Both writes of a sample carry the same value, so a tap that hits
    // either write address takes the incoming sample.
    assign fwd = (job_reg.wr_en[0] && rd_addr == job_reg.wr_addr0) ||
                 (job_reg.wr_en[1] && rd_addr == job_reg.wr_addr1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = job_reg.wr_addr0;
        mem_wdata = job_reg.sample;
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (busy_reg && cnt_reg == CNT_W'(0))
        begin
            mem_we = job_reg.wr_en[0];
        end
        else if (busy_reg && cnt_reg == CNT_W'(1))
        begin
            mem_we    = job_reg.wr_en[1];
            mem_waddr = job_reg.wr_addr1;
        end
    end

    assign rd_val = rd_fwd_reg ? rd_sample_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (job_valid && job_ready)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rd_pend_reg <= issue;
            if (rd_pend_reg && rd_idx_reg == CNT_LAST)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        if (issue)
        begin
            rd_idx_reg    <= cnt_reg;
            rd_fwd_reg    <= fwd;
            rd_sample_reg <= job_reg.sample;
            rd_led_reg    <= job_reg.led;
            rd_stut_reg   <= job_reg.stutter;
        end
        if (rd_pend_reg && rd_idx_reg != CNT_LAST)
        begin
            asm_reg[rd_idx_reg[CNT_W-1:0]] <= rd_val;
        end
        if (rd_pend_reg && rd_idx_reg == CNT_LAST)
        begin
            out_tap_reg[0] <= asm_reg[0];
            out_tap_reg[1] <= asm_reg[1];
            out_tap_reg[2] <= rd_stut_reg ? '0 : asm_reg[2];
            out_tap_reg[3] <= rd_stut_reg ? '0 : rd_val;
            out_led_reg    <= rd_led_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign tap_one   = $signed(out_tap_reg[0]);
    assign tap_two   = $signed(out_tap_reg[1]);
    assign tap_three = $signed(out_tap_reg[2]);
    assign tap_four  = $signed(out_tap_reg[3]);
    assign led_on    = out_led_reg;

endmodule

### rtl/glitch_stutter_delay_line.sv
// Top level of the glitch and stutter delay line: configuration registers and core.
//
//  Channel  Signals                                          Beat when
//  -------  -----------------------------------------------  --------------------------
//  input    operation sample_in block_last tap_select        in_valid && in_ready
//           delay_ms
//  output   tap_one tap_two tap_three tap_four led_on        out_valid && out_ready
//  config   cfg_wr_en cfg_index cfg_data                     cfg_wr_en
//
// An enabled sample makes one read per tap on the memory's single read port; a
// set-delay beat keeps the input closed through the ms-to-samples multiplier steps.
// Disabled samples are taken at once when the sequencer is free.
// After reset the memory is cleared one word a cycle: in_ready stays low until all
// STORE_DEPTH (16384) words are cleared; configuration writes are taken as usual.
// A result waiting at the output holds back only the final read of the next sample.
module glitch_stutter_delay_line (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic signed [gsd_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 block_last,
    input  logic [gsd_pkg::TAP_SEL_W-1:0]        tap_select,
    input  logic [gsd_pkg::MS_W-1:0]             delay_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_one,
    output logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_two,
    output logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_three,
    output logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_four,
    output logic                                 led_on
);
    import gsd_pkg::*;

    cfg_t cfg_reg;
    logic job_valid;
    logic job_ready;
    job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                CFG_STUTTER_MODE: cfg_reg.stutter_mode <= cfg_data[0];
                CFG_CYCLE_LIMIT:  cfg_reg.cycle_limit  <= cfg_data[COUNT_W-1:0];
                CFG_LOOP_LENGTH:  cfg_reg.loop_length  <= cfg_data[LOOP_W-1:0];
                CFG_LAG_COUNT:    cfg_reg.lag_count    <= cfg_data[COUNT_W-1:0];
                CFG_RECORD_HOLD:  cfg_reg.record_hold  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    gsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .sample_in  (sample_in),
        .block_last (block_last),
        .tap_select (tap_select),
        .delay_ms   (delay_ms),
        .job_ready  (job_ready),
        .job_valid  (job_valid),
        .job        (job)
    );

    gsd_mem_seq u_mem_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tap_one   (tap_one),
        .tap_two   (tap_two),
        .tap_three (tap_three),
        .tap_four  (tap_four),
        .led_on    (led_on)
    );

endmodule

### rtl/gsd_checker.sv
// Port-level checks of the glitch and stutter delay line, bound to its top level.
module gsd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_wr_en,
    input logic [gsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [gsd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 operation,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_one,
    input logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_two,
    input logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_three,
    input logic signed [gsd_pkg::SAMPLE_W-1:0]  tap_four,
    input logic                                 led_on
);
    import gsd_pkg::*;

    logic enable_seen_reg;
    logic stutter_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_seen_reg  <= 1'b0;
            stutter_seen_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_ENABLE)
            begin
                enable_seen_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_STUTTER_MODE)
            begin
                stutter_seen_reg <= cfg_data[0];
            end
        end
    end

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tap_one) && $stable(tap_two)
            && $stable(tap_three) && $stable(tap_four) && $stable(led_on))
        else $error("result beat changed while stalled");

    // The delay conversion keeps the input closed through its multiply, reciprocal and fix states.
    a_set_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_SET_DELAY
            |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input reopened during delay conversion");

    // Only an enabled block produces results.
    a_no_result_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> enable_seen_reg)
        else $error("result produced while disabled");

    // The third and fourth taps are silent in stutter mode.
    a_stutter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stutter_seen_reg |-> tap_three == '0 && tap_four == '0)
        else $error("upper taps not silent in stutter mode");

endmodule

bind glitch_stutter_delay_line gsd_checker u_gsd_checker (.*);

### sim/tb.sv
// Self-checking testbench of the glitch and stutter delay line, with a tap predictor class.
`timescale 1ns / 1ps

module tb;
    import gsd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [TAP_SEL_W-1:0] sel;
        logic [MS_W-1:0]     ms;
    } stim_t;

    typedef struct packed {
        logic [NUM_TAPS-1:0][TAP_W-1:0] taps;
        logic                           led;
    } tap_beat_t;

    class delay_line_tracker;
        logic [SAMPLE_W-1:0] store [STORE_DEPTH];
        logic [ADDR_W-1:0]   wr_pos;
        logic [WPS_W-1:0]    wr_pos_second;
        logic [TAP_W-1:0]    tap_pos [NUM_TAPS];
        logic                phase;
        logic [COUNT_W-1:0]  loop_count;
        logic                led;
        cfg_t                regs;
        tap_beat_t           expected_taps [$];
        int                  mismatches;
        int                  restarts;
        int                  moves;

        function new();
            foreach (store[i])
                store[i] = '0;
            foreach (tap_pos[i])
                tap_pos[i] = '0;
            wr_pos        = '0;
            wr_pos_second = '0;
            phase         = 1'b1;
            loop_count    = '0;
            led           = 1'b0;
            regs          = '0;
            mismatches    = 0;
            restarts      = 0;
            moves         = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ENABLE:       regs.enable       = value[0];
                CFG_STUTTER_MODE: regs.stutter_mode = value[0];
                CFG_CYCLE_LIMIT:  regs.cycle_limit  = value[COUNT_W-1:0];
                CFG_LOOP_LENGTH:  regs.loop_length  = value[LOOP_W-1:0];
                CFG_LAG_COUNT:    regs.lag_count    = value[COUNT_W-1:0];
                CFG_RECORD_HOLD:  regs.record_hold  = value[0];
                default:          ;
            endcase
        endfunction

        function void note_item(stim_t it);
            logic              was_write;
            longint unsigned   span;
            logic [ADDR_W-1:0] spot;
            tap_beat_t         res;
            was_write = phase;
            res       = '0;
            if (it.op == OP_SET_DELAY)
            begin
                moves++;
                if (!regs.stutter_mode)
                begin
                    span = 64'(it.ms);
                    span = (span * SAMPLE_RATE_HZ / MS_PER_SECOND) & 64'hFFFF;
                    // The depth is a power of two, so the low bits are the distance modulo depth.
                    spot = wr_pos - span[ADDR_W-1:0];
                    tap_pos[it.sel] = TAP_W'(spot);
                end
                return;
            end
            phase = it.last ? 1'b1 : ~was_write;
            if (!regs.enable)
                return;
            if (!regs.stutter_mode)
            begin
                if (was_write)
                begin
                    store[wr_pos] = it.sample;
                    wr_pos = wr_pos + 1'b1;
                end
                for (int k = 0; k < NUM_TAPS; k++)
                    res.taps[k] = store[tap_pos[k][ADDR_W-1:0]];
                if (!was_write)
                begin
                    for (int k = 0; k < NUM_TAPS; k++)
                    begin
                        spot = tap_pos[k][ADDR_W-1:0] + 1'b1;
                        tap_pos[k] = TAP_W'(spot);
                    end
                end
            end
            else
            begin
                if (was_write && !regs.record_hold)
                begin
                    if (wr_pos < SECOND_REGION_START)
                    begin
                        store[wr_pos] = it.sample;
                        wr_pos = wr_pos + 1'b1;
                    end
                    if (wr_pos_second < STORE_DEPTH)
                    begin
                        store[wr_pos_second[ADDR_W-1:0]] = it.sample;
                        wr_pos_second = wr_pos_second + 1'b1;
                    end
                end
                res.taps[0] = store[tap_pos[0][ADDR_W-1:0]];
                res.taps[1] = store[tap_pos[1][ADDR_W-1:0]];
                if (!was_write)
                begin
                    tap_pos[0] = tap_pos[0] + 1'b1;
                    tap_pos[1] = tap_pos[1] + 1'b1;
                end
                // Loop bookkeeping happens only on the closing beat of a block.
                if (it.last)
                begin
                    if (tap_pos[0] >= regs.loop_length)
                    begin
                        led = 1'b1;
                        restarts++;
                        loop_count = loop_count + 1'b1;
                        if (loop_count == regs.lag_count)
                            wr_pos_second = WPS_W'(SECOND_REGION_START);
                        if (loop_count >= regs.cycle_limit)
                        begin
                            loop_count = '0;
                            wr_pos     = '0;
                        end
                        tap_pos[0] = '0;
                        tap_pos[1] = TAP_W'(SECOND_REGION_START);
                    end
                    else if (tap_pos[0] >= LED_OFF_INDEX)
                        led = 1'b0;
                end
            end
            res.led = led;
            expected_taps.push_back(res);
        endfunction

        function void note_mismatch(tap_beat_t want, tap_beat_t got, string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected taps %h %h %h %h led %b, got %h %h %h %h led %b",
                         what, want.taps[0], want.taps[1], want.taps[2], want.taps[3],
                         want.led, got.taps[0], got.taps[1], got.taps[2], got.taps[3],
                         got.led);
        endfunction

        function void check_taps(tap_beat_t got);
            tap_beat_t want;
            logic      bad;
            if (expected_taps.size() == 0)
            begin
                note_mismatch('0, got, "unexpected output beat");
                return;
            end
            want = expected_taps.pop_front();
            bad  = 1'b0;
            for (int k = 0; k < NUM_TAPS; k++)
                if (got.taps[k] !== want.taps[k])
                    bad = 1'b1;
            if (got.led !== want.led)
                bad = 1'b1;
            if (bad)
                note_mismatch(want, got, "output beat mismatch");
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                  block_last;
    logic [TAP_SEL_W-1:0]  tap_select;
    logic [MS_W-1:0]       delay_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [SAMPLE_W-1:0] tap_one;
    logic signed [SAMPLE_W-1:0] tap_two;
    logic signed [SAMPLE_W-1:0] tap_three;
    logic signed [SAMPLE_W-1:0] tap_four;
    logic                  led_on;

    delay_line_tracker line_model = new();
    stim_t             stim_queue [$];
    stim_t             offered;
    tap_beat_t         got;
    int                items_pushed = 0;
    int                beats_taken  = 0;
    int                beats_out    = 0;
    int                block_pos    = 0;
    int                burst_left   = 1;
    int                gap_left     = 0;
    int                hold_left    = 0;
    int                style        = 0;
    int                style_left   = 0;
    bit                held_once    = 1'b0;
    int                cycles       = 0;

    glitch_stutter_delay_line dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .sample_in  (sample_in),
        .block_last (block_last),
        .tap_select (tap_select),
        .delay_ms   (delay_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tap_one    (tap_one),
        .tap_two    (tap_two),
        .tap_three  (tap_three),
        .tap_four   (tap_four),
        .led_on     (led_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        case ($urandom_range(0, 3))
            0, 1:    return MS_W'($urandom_range(0, 12));
            2:       return MS_W'($urandom_range(0, 400));
            default: return MS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void push_sample(logic [SAMPLE_W-1:0] value, logic last);
        stim_t it;
        it.op     = OP_SAMPLE;
        it.sample = value;
        it.last   = last;
        it.sel    = TAP_SEL_W'($urandom_range(0, 3));
        it.ms     = MS_W'($urandom_range(0, 65535));
        stim_queue.push_back(it);
        items_pushed++;
    endfunction

    function automatic void push_delay(logic [TAP_SEL_W-1:0] sel, logic [MS_W-1:0] ms);
        stim_t it;
        it.op     = OP_SET_DELAY;
        it.sample = SAMPLE_W'($urandom);
        it.last   = 1'($urandom_range(0, 1));
        it.sel    = sel;
        it.ms     = ms;
        stim_queue.push_back(it);
        items_pushed++;
    endfunction

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        line_model.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic en, input logic stut, input int climit,
                                  input int llen, input int lag, input logic hold);
        put_reg(CFG_ENABLE, CFG_DATA_W'(en));
        put_reg(CFG_STUTTER_MODE, CFG_DATA_W'(stut));
        put_reg(CFG_CYCLE_LIMIT, CFG_DATA_W'(climit));
        put_reg(CFG_LOOP_LENGTH, CFG_DATA_W'(llen));
        put_reg(CFG_LAG_COUNT, CFG_DATA_W'(lag));
        put_reg(CFG_RECORD_HOLD, CFG_DATA_W'(hold));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Beats without a result may still be in flight when the queue drains.
    task automatic wait_idle();
        while (beats_taken != items_pushed || line_model.expected_taps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic en, input logic stut, input int climit,
                             input int llen, input int lag, input logic hold,
                             input int count, input int blk_len);
        logic last;
        wait_idle();
        apply_settings(en, stut, climit, llen, lag, hold);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_delay(TAP_SEL_W'($urandom_range(0, 3)), pick_ms());
            else
            begin
                // Mostly whole blocks, with the odd block cut short.
                last = (block_pos >= blk_len - 1) || ($urandom_range(0, 49) == 0);
                block_pos = last ? 0 : block_pos + 1;
                push_sample(pick_sample(), last);
            end
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    initial
    begin
        in_valid   <= 1'b0;
        operation  <= OP_SAMPLE;
        sample_in  <= '0;
        block_last <= 1'b0;
        tap_select <= '0;
        delay_ms   <= '0;
        forever
        begin
            @(posedge clk);
            if (in_valid && in_ready)
            begin
                line_model.note_item(offered);
                beats_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_queue.size() > 0)
                begin
                    offered = stim_queue.pop_front();
                    operation  <= offered.op;
                    sample_in  <= offered.sample;
                    block_last <= offered.last;
                    tap_select <= offered.sel;
                    delay_ms   <= offered.ms;
                    in_valid   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in changing styles, and once for a long stretch.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.taps = {tap_four, tap_three, tap_two, tap_one};
                got.led  = led_on;
                line_model.check_taps(got);
                beats_out++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_once && beats_out >= 300)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 2);
                    style_left = $urandom_range(10, 80);
                end
                else
                    style_left--;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d beats still expected.",
                 cycles, line_model.expected_taps.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic en;
        logic stut;
        logic hold;
        int   climit;
        int   llen;
        int   lag;
        int   blk_len;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Delay mode: one tap on the writer, others at short, wrapped and long distances.
        apply_settings(1'b1, 1'b0, 0, 0, 0, 1'b0);
        push_delay(2'd0, 16'd0);
        push_delay(2'd1, 16'd1);
        push_delay(2'd2, 16'hFFFF);
        push_delay(2'd3, 16'd1000);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h1234, 1'b1);
        push_sample(16'h5A5A, 1'b0);

        // Disabled: samples only flip the phase, tap moves still land.
        wait_idle();
        apply_settings(1'b0, 1'b0, 0, 0, 0, 1'b0);
        push_sample(16'h4321, 1'b0);
        push_delay(2'd1, 16'd5);
        push_sample(16'hA5A5, 1'b1);

        // Stutter with zero loop length: every block end restarts the loop.
        wait_idle();
        apply_settings(1'b1, 1'b1, 0, 0, 0, 1'b0);
        push_delay(2'd0, 16'd3);
        push_sample(16'h0F0F, 1'b0);
        push_sample(16'hF0F0, 1'b1);
        wait_idle();
        apply_settings(1'b1, 1'b1, 0, 0, 0, 1'b1);
        push_sample(16'h7777, 1'b0);
        push_sample(16'h8888, 1'b1);

        // A tap far behind the writer, then a block end short of the loop clears the LED.
        wait_idle();
        apply_settings(1'b1, 1'b0, 0, 0, 0, 1'b0);
        push_delay(2'd0, 16'd400);
        wait_idle();
        apply_settings(1'b1, 1'b1, 255, 16384, 255, 1'b0);
        push_sample(16'h2468, 1'b1);

        run_phase(1'b1, 1'b0, 255, 16384, 255, 1'b1, 150, 128);
        run_phase(1'b1, 1'b1, 0, 0, 0, 1'b0, 120, 8);
        run_phase(1'b1, 1'b1, 255, 5, 255, 1'b0, 100, 16);
        run_phase(1'b1, 1'b1, 2, 30, 1, 1'b1, 60, 32);
        for (int p = 0; p < 5; p++)
        begin
            en      = ($urandom_range(0, 7) != 0);
            stut    = 1'($urandom_range(0, 1));
            hold    = ($urandom_range(0, 3) == 0);
            climit  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 4);
            llen    = $urandom_range(0, 80);
            lag     = $urandom_range(0, 4);
            case ($urandom_range(0, 3))
                0:       blk_len = 8;
                1:       blk_len = 16;
                2:       blk_len = 32;
                default: blk_len = 128;
            endcase
            run_phase(en, stut, climit, llen, lag, hold, 100, blk_len);
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Covered %0d input beats (%0d tap moves) and %0d output beats.",
                 beats_taken, line_model.moves, beats_out);
        $display("Stutter loop restarts seen: %0d; mismatching beats: %0d.",
                 line_model.restarts, line_model.mismatches);
        if (line_model.mismatches == 0 && line_model.expected_taps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
